/* hw/rtl/stl_pkg.sv */
// Shared types, codes and character classes for the source token lexer.
package stl_pkg;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_STRING = 2'd3;

  localparam logic [4:0] KIND_EOF          = 5'd0;
  localparam logic [4:0] KIND_IDENT        = 5'd1;
  localparam logic [4:0] KIND_RETURN       = 5'd2;
  localparam logic [4:0] KIND_AUTO         = 5'd3;
  localparam logic [4:0] KIND_NUMBER       = 5'd4;
  localparam logic [4:0] KIND_STRING       = 5'd5;
  localparam logic [4:0] KIND_LPAREN       = 5'd6;
  localparam logic [4:0] KIND_RPAREN       = 5'd7;
  localparam logic [4:0] KIND_LBRACE       = 5'd8;
  localparam logic [4:0] KIND_RBRACE       = 5'd9;
  localparam logic [4:0] KIND_SEMI         = 5'd10;
  localparam logic [4:0] KIND_PLUS         = 5'd11;
  localparam logic [4:0] KIND_MINUS        = 5'd12;
  localparam logic [4:0] KIND_STAR         = 5'd13;
  localparam logic [4:0] KIND_SLASH        = 5'd14;
  localparam logic [4:0] KIND_ASSIGN       = 5'd15;
  localparam logic [4:0] KIND_COMMA        = 5'd16;
  localparam logic [4:0] KIND_UNKNOWN      = 5'd17;
  localparam logic [4:0] KIND_UNTERMINATED = 5'd18;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
  } token_t;

  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } token_pair_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h0D || c == 8'h09 || c == 8'h0A;
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h3B:   k = KIND_SEMI;
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h3D:   k = KIND_ASSIGN;
      8'h2C:   k = KIND_COMMA;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] kw_return_char(input logic [2:0] k);
    logic [7:0] ch;
    case (k)
      3'd0:    ch = 8'h72;
      3'd1:    ch = 8'h65;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h75;
      3'd4:    ch = 8'h72;
      3'd5:    ch = 8'h6E;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_auto_char(input logic [1:0] k);
    logic [7:0] ch;
    case (k)
      2'd0:    ch = 8'h61;
      2'd1:    ch = 8'h75;
      2'd2:    ch = 8'h74;
      2'd3:    ch = 8'h6F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* hw/rtl/source_token_lexer_unit.sv */
// Top level of the source token lexer: scanner, token queue and emitter.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+-----------------------------
//   in      | in_valid, in_stall, char_byte, end_of_input | source byte request
//   out     | out_valid, out_stall, token_kind,          | token request, up to two
//           | token_start, token_length, last_of_run     | per input request
//
// One input request per cycle while in_stall is low; a request that yields two tokens sends both in turn.
// Scanner state updates in the cycle of acceptance; its tokens pass through the pair queue to the output.
// A two-entry pair queue decouples the sides: in_stall rises only when it is full.
// Synchronous active-high reset empties the queue and restarts the scanner at offset zero.
module source_token_lexer_unit #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic        last_of_run
);

  logic                 q_full, q_empty, q_push, q_pop;
  stl_pkg::token_pair_t q_push_data, q_head;

  stl_front #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_byte    (char_byte),
    .end_of_input (end_of_input),
    .q_full       (q_full),
    .push         (q_push),
    .push_data    (q_push_data)
  );

  stl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  stl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .empty        (q_empty),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

endmodule

/* hw/rtl/stl_front.sv */
// Front scanner: accepts source bytes, keeps the scan state and forms token pairs.
module stl_front #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           char_byte,
  input  logic                 end_of_input,
  input  logic                 q_full,
  output logic                 push,
  output stl_pkg::token_pair_t push_data
);

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
  localparam logic [POSITION_WIDTH-1:0] POS_ONE = {{(POSITION_WIDTH-1){1'b0}}, 1'b1};

  logic [1:0]                mode, mode_next;
  logic [POSITION_WIDTH-1:0] pos, pos_next;
  logic [POSITION_WIDTH-1:0] origin, origin_next;
  logic [2:0]                kprog, kprog_next;
  logic [1:0]                kcand, kcand_next;

  logic                      accept;
  logic [POSITION_WIDTH-1:0] pos_inc;
  logic [POSITION_WIDTH-1:0] open_len;
  logic [4:0]                ident_kind;
  logic [1:0]                trk_cand;
  logic [2:0]                trk_prog;
  logic                      do_idle;
  logic                      has_a, has_b;
  logic [4:0]                a_kind, b_kind;
  logic [POSITION_WIDTH-1:0] a_start, a_len, b_start, b_len;
  stl_pkg::token_t           tok_a, tok_b;

  function automatic logic [15:0] cut16(input logic [POSITION_WIDTH-1:0] v);
    logic [POSITION_WIDTH+15:0] w;
    w = {16'b0, v};
    return w[15:0];
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign pos_inc  = (pos == POS_MAX) ? pos : pos + POS_ONE;
  assign open_len = (pos >= origin) ? pos - origin : '0;

  always_comb begin
    if (kcand[0] && kprog == 3'd6) begin
      ident_kind = stl_pkg::KIND_RETURN;
    end else if (kcand[1] && kprog == 3'd4) begin
      ident_kind = stl_pkg::KIND_AUTO;
    end else begin
      ident_kind = stl_pkg::KIND_IDENT;
    end
  end

  always_comb begin
    trk_cand = kcand;
    if (kprog >= 3'd6 || char_byte != stl_pkg::kw_return_char(kprog)) begin
      trk_cand[0] = 1'b0;
    end
    if (kprog >= 3'd4 || char_byte != stl_pkg::kw_auto_char(kprog[1:0])) begin
      trk_cand[1] = 1'b0;
    end
    trk_prog = (kprog == 3'd7) ? kprog : kprog + 3'd1;
  end

  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    origin_next = origin;
    kprog_next  = kprog;
    kcand_next  = kcand;
    do_idle     = 1'b0;
    has_a       = 1'b0;
    has_b       = 1'b0;
    a_kind      = ident_kind;
    a_start     = origin;
    a_len       = open_len;
    b_kind      = stl_pkg::KIND_EOF;
    b_start     = pos;
    b_len       = '0;
    if (end_of_input) begin
      has_a = (mode != stl_pkg::MODE_IDLE);
      case (mode)
        stl_pkg::MODE_NUMBER: a_kind = stl_pkg::KIND_NUMBER;
        stl_pkg::MODE_STRING: a_kind = stl_pkg::KIND_UNTERMINATED;
        default:              a_kind = ident_kind;
      endcase
      has_b       = 1'b1;
      mode_next   = stl_pkg::MODE_IDLE;
      pos_next    = '0;
      origin_next = '0;
      kprog_next  = 3'd0;
      kcand_next  = 2'b11;
    end else begin
      pos_next = pos_inc;
      case (mode)
        stl_pkg::MODE_IDENT: begin
          if (stl_pkg::is_ident_char(char_byte)) begin
            kcand_next = trk_cand;
            kprog_next = trk_prog;
          end else begin
            has_a   = 1'b1;
            do_idle = 1'b1;
          end
        end
        stl_pkg::MODE_NUMBER: begin
          if (!stl_pkg::is_digit(char_byte)) begin
            has_a   = 1'b1;
            a_kind  = stl_pkg::KIND_NUMBER;
            do_idle = 1'b1;
          end
        end
        stl_pkg::MODE_STRING: begin
          if (char_byte == stl_pkg::CH_QUOTE) begin
            has_a     = 1'b1;
            a_kind    = stl_pkg::KIND_STRING;
            mode_next = stl_pkg::MODE_IDLE;
          end
        end
        default: do_idle = 1'b1;
      endcase
      if (do_idle) begin
        mode_next = stl_pkg::MODE_IDLE;
        if (stl_pkg::is_space(char_byte)) begin
          mode_next = stl_pkg::MODE_IDLE;
        end else if (stl_pkg::is_letter(char_byte) || char_byte == stl_pkg::CH_UNDER) begin
          mode_next   = stl_pkg::MODE_IDENT;
          origin_next = pos;
          kprog_next  = 3'd1;
          kcand_next  = {char_byte == stl_pkg::kw_auto_char(2'd0),
                         char_byte == stl_pkg::kw_return_char(3'd0)};
        end else if (stl_pkg::is_digit(char_byte)) begin
          mode_next   = stl_pkg::MODE_NUMBER;
          origin_next = pos;
        end else if (char_byte == stl_pkg::CH_QUOTE) begin
          mode_next   = stl_pkg::MODE_STRING;
          origin_next = pos_inc;
        end else begin
          has_b   = 1'b1;
          b_kind  = stl_pkg::punct_kind(char_byte);
          b_start = pos;
          b_len   = POS_ONE;
        end
      end
    end
  end

  assign tok_a = '{kind: a_kind, start: cut16(a_start), length: cut16(a_len)};
  assign tok_b = '{kind: b_kind, start: cut16(b_start), length: cut16(b_len)};

  assign push             = accept && (has_a || has_b);
  assign push_data.two    = has_a && has_b;
  assign push_data.first  = has_a ? tok_a : tok_b;
  assign push_data.second = tok_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= stl_pkg::MODE_IDLE;
      pos    <= '0;
      origin <= '0;
      kprog  <= 3'd0;
      kcand  <= 2'b11;
    end else if (accept) begin
      mode   <= mode_next;
      pos    <= pos_next;
      origin <= origin_next;
      kprog  <= kprog_next;
      kcand  <= kcand_next;
    end
  end

`ifndef SYNTHESIS
  a_eoi_restart: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_input |=> mode == stl_pkg::MODE_IDLE && pos == '0 && kcand == 2'b11)
    else $error("scan state not restarted after end of input");
`endif

endmodule

/* hw/rtl/stl_queue.sv */
// Short token-pair queue between the front scanner and the back emitter.
module stl_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  stl_pkg::token_pair_t push_data,
  output logic                 full,
  input  logic                 pop,
  output stl_pkg::token_pair_t head,
  output logic                 empty
);

  localparam int PTR_W = (stl_pkg::QUEUE_DEPTH > 1) ? $clog2(stl_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(stl_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(stl_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(stl_pkg::QUEUE_DEPTH);

  stl_pkg::token_pair_t entries [stl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [CNT_W-1:0]     count;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue count out of range");
`endif

endmodule

/* hw/rtl/stl_back.sv */
// Back emitter: sends the one or two tokens of each queued pair on the output channel.
module stl_back (
  input  logic                 clk,
  input  logic                 rst,
  input  stl_pkg::token_pair_t head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [4:0]           token_kind,
  output logic [15:0]          token_start,
  output logic [15:0]          token_length,
  output logic                 last_of_run
);

  logic            sel;
  logic            out_accept;
  stl_pkg::token_t cur;

  assign cur          = sel ? head.second : head.first;
  assign out_valid    = !empty;
  assign token_kind   = cur.kind;
  assign token_start  = cur.start;
  assign token_length = cur.length;
  assign last_of_run  = sel || !head.two;
  assign out_accept   = out_valid && !out_stall;
  assign pop          = out_accept && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (out_accept) begin
      sel <= !last_of_run;
    end
  end

`ifndef SYNTHESIS
  a_sel_on_pair: assert property (@(posedge clk) disable iff (rst) sel |-> head.two && !empty)
    else $error("second token selected without a pair at the head");
`endif

endmodule
